// File: rtl/rima_pkg.sv
// shared types and constants of the region image moment accumulator
package rima_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_ORDER_X      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ORDER_Y      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_CENTER_X     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_CENTER_Y     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_WEIGHTED     = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 3'd6;

  localparam logic [12:0] IMAGE_DIM_RESET = 13'h1000;

  localparam logic [63:0] POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NEG_LIMIT = 64'h8000_0000_0000_0000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_TERM,
    ST_SUM,
    ST_EMIT
  } rima_state_e;

  typedef struct packed {
    logic load;
    logic mul;
    logic acc;
    logic term;
    logic sum;
    logic emit;
  } rima_cmd_t;

  typedef struct packed {
    logic keep;
    logic last;
    logic more;
    logic out_free;
  } rima_status_t;

endpackage

// File: rtl/rima_ctrl.sv
// sequencer of the moment accumulator: load, multiply steps, term, sum, emit
module rima_ctrl import rima_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  rima_status_t status_i,
  output rima_cmd_t    cmd_o
);

  rima_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        if (!status_i.keep) begin
          state_d = status_i.last ? ST_EMIT : ST_IDLE;
        end else if (status_i.more) begin
          state_d = ST_ACC;
        end else begin
          state_d = ST_TERM;
        end
      end
      ST_ACC:  state_d = ST_MUL;
      ST_TERM: state_d = ST_SUM;
      ST_SUM: begin
        state_d = status_i.last ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      ST_MUL:  cmd_o.mul  = status_i.keep && status_i.more;
      ST_ACC:  cmd_o.acc  = 1'b1;
      ST_TERM: cmd_o.term = 1'b1;
      ST_SUM:  cmd_o.sum  = 1'b1;
      ST_EMIT: cmd_o.emit = status_i.out_free;
      default: cmd_o      = '0;
    endcase
  end

endmodule

// File: rtl/rima_dp.sv
// datapath: distances, shared saturating multiplier, term clipping, accumulator, result register
module rima_dp import rima_pkg::*; #(
  parameter int COORD_BITS = 12,
  parameter int MAX_ORDER  = 3
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rima_cmd_t             cmd_i,
  output rima_status_t          status_o,
  input  logic [1:0]            order_x_i,
  input  logic [1:0]            order_y_i,
  input  logic [15:0]           center_x_i,
  input  logic [15:0]           center_y_i,
  input  logic                  weighted_i,
  input  logic [12:0]           image_width_i,
  input  logic [12:0]           image_height_i,
  input  logic [COORD_BITS-1:0] pix_x_i,
  input  logic [COORD_BITS-1:0] pix_y_i,
  input  logic [7:0]            pix_value_i,
  input  logic                  last_pixel_i,
  output logic                  res_valid_o,
  input  logic                  res_stall_i,
  output logic [63:0]           moment_o,
  output logic                  saturated_o
);

  localparam int DIST_W = (COORD_BITS + 4 > 16) ? COORD_BITS + 4 : 16;
  localparam int PP_W   = 32 + DIST_W;
  localparam int FULL_W = 64 + DIST_W;
  localparam int CNT_W  = 4;

  function automatic logic [1:0] clamp_order(logic [1:0] o);
    logic [1:0] r;
    r = o;
    if (int'(o) > MAX_ORDER) begin
      r = 2'(MAX_ORDER);
    end
    return r;
  endfunction

  // item registers
  logic [DIST_W-1:0] mx_q, my_q;
  logic              nx_q, ny_q;
  logic [7:0]        w_q;
  logic              keep_q, last_q;
  logic [1:0]        p_q, q_q;
  logic [CNT_W-1:0]  k_q;

  // multiplier and accumulator registers
  logic [PP_W-1:0]   pp_lo_q, pp_hi_q;
  logic [63:0]       r_q, r_d;
  logic              mul_ovf_q, mul_ovf_d;
  logic [63:0]       term_q;
  logic              term_clip_q;
  logic [63:0]       sum_q, sum_d;
  logic              seen_q, seen_d;
  logic [63:0]       moment_q;
  logic              saturated_q;
  logic              out_valid_q;

  // load side
  logic [15:0]       x_ext, y_ext;
  logic              keep_d;
  logic [DIST_W:0]   dx, dy;
  logic [DIST_W-1:0] mx_d, my_d;

  assign x_ext  = 16'(pix_x_i);
  assign y_ext  = 16'(pix_y_i);
  assign keep_d = !weighted_i ||
                  (x_ext != 16'd0 && x_ext <= 16'(image_width_i) &&
                   y_ext != 16'd0 && y_ext <= 16'(image_height_i));

  assign dx   = (DIST_W+1)'({pix_x_i, 4'b0000}) - (DIST_W+1)'(center_x_i);
  assign dy   = (DIST_W+1)'({pix_y_i, 4'b0000}) - (DIST_W+1)'(center_y_i);
  assign mx_d = dx[DIST_W] ? DIST_W'(-dx) : dx[DIST_W-1:0];
  assign my_d = dy[DIST_W] ? DIST_W'(-dy) : dy[DIST_W-1:0];

  // step selection
  logic [CNT_W-1:0]  total, pq_sum;
  logic [DIST_W-1:0] factor;

  assign pq_sum = CNT_W'(p_q) + CNT_W'(q_q);
  assign total  = pq_sum + CNT_W'(1);

  always_comb begin
    if (k_q < CNT_W'(p_q)) begin
      factor = mx_q;
    end else if (k_q < pq_sum) begin
      factor = my_q;
    end else begin
      factor = DIST_W'(w_q);
    end
  end

  // partial product combine
  logic [FULL_W-1:0] full;
  logic              step_ovf;

  assign full     = FULL_W'({pp_hi_q, 32'h0}) + FULL_W'(pp_lo_q);
  assign step_ovf = |full[FULL_W-1:64];

  // term forming
  logic        neg, clip;
  logic [63:0] term_d;

  assign neg  = ((nx_q & p_q[0]) != (ny_q & q_q[0])) && (r_q != 64'd0);
  assign clip = mul_ovf_q || (!neg && r_q[63]) || (neg && r_q > NEG_LIMIT);

  always_comb begin
    if (clip) begin
      term_d = neg ? NEG_LIMIT : POS_LIMIT;
    end else begin
      term_d = neg ? (64'd0 - r_q) : r_q;
    end
  end

  // saturating accumulate
  logic [63:0] add;
  logic        add_ovf;

  assign add     = sum_q + term_q;
  assign add_ovf = (sum_q[63] == term_q[63]) && (add[63] != sum_q[63]);

  always_comb begin
    r_d       = r_q;
    mul_ovf_d = mul_ovf_q;
    if (cmd_i.load) begin
      r_d       = 64'd1;
      mul_ovf_d = 1'b0;
    end else if (cmd_i.acc) begin
      r_d       = step_ovf ? '1 : full[63:0];
      mul_ovf_d = mul_ovf_q | step_ovf;
    end
  end

  always_comb begin
    sum_d  = sum_q;
    seen_d = seen_q;
    if (cmd_i.emit) begin
      sum_d  = 64'd0;
      seen_d = 1'b0;
    end else if (cmd_i.sum) begin
      sum_d  = add_ovf ? (sum_q[63] ? NEG_LIMIT : POS_LIMIT) : add;
      seen_d = seen_q | term_clip_q | add_ovf;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_q      <= 1'b0;
      last_q      <= 1'b0;
      p_q         <= 2'd0;
      q_q         <= 2'd0;
      k_q         <= '0;
      sum_q       <= 64'd0;
      seen_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      sum_q  <= sum_d;
      seen_q <= seen_d;
      if (cmd_i.load) begin
        keep_q <= keep_d;
        last_q <= last_pixel_i;
        p_q    <= clamp_order(order_x_i);
        q_q    <= clamp_order(order_y_i);
        k_q    <= '0;
      end else if (cmd_i.acc) begin
        k_q <= k_q + CNT_W'(1);
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!res_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    r_q       <= r_d;
    mul_ovf_q <= mul_ovf_d;
    if (cmd_i.load) begin
      mx_q <= mx_d;
      my_q <= my_d;
      nx_q <= dx[DIST_W];
      ny_q <= dy[DIST_W];
      w_q  <= weighted_i ? pix_value_i : 8'd1;
    end
    if (cmd_i.mul) begin
      pp_lo_q <= PP_W'(r_q[31:0]) * PP_W'(factor);
      pp_hi_q <= PP_W'(r_q[63:32]) * PP_W'(factor);
    end
    if (cmd_i.term) begin
      term_q      <= term_d;
      term_clip_q <= clip;
    end
    if (cmd_i.emit) begin
      moment_q    <= sum_q;
      saturated_q <= seen_q;
    end
  end

  assign status_o.keep     = keep_q;
  assign status_o.last     = last_q;
  assign status_o.more     = k_q < total;
  assign status_o.out_free = !out_valid_q || !res_stall_i;

  assign res_valid_o = out_valid_q;
  assign moment_o    = moment_q;
  assign saturated_o = saturated_q;

`ifndef SYNTHESIS
  a_emit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |=> (sum_q == 64'd0) && !seen_q && out_valid_q)
    else $error("accumulator not cleared after result");

  a_emit_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_q || !res_stall_i))
    else $error("result register overwritten while stalled");

  a_count_keep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load && !weighted_i |=> keep_q)
    else $error("unweighted pixel dropped");

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    k_q <= total)
    else $error("multiply step count ran past its end");
`endif

endmodule

// File: rtl/region_image_moment_accumulator.sv
// top level of the region image moment accumulator
// Usage:
//   Configuration: cfg_valid_i/cfg_ready_o write cfg_data_i into register cfg_index_i
//   (order_x, order_y, center_x, center_y, weighted, image_width, image_height).
//   Write only while the block is idle; cfg_ready_o is always high.
//   Pixel channel: pix_valid_i/pix_stall_o, one region pixel per transfer; the pixel
//   with last_pixel_i set closes the region.
//   Result channel: res_valid_o/res_stall_i, one result per region (moment_o, saturated_o)
//   held in an output register, so the next region can start while it waits.
//   Sequence: a kept pixel is loaded, then the shared 64x16 multiplier does one power
//   step per multiply and accumulate pair (partial products, then combine and saturate),
//   one step per power of the x and y distances and one for the weight; then the term
//   is formed and summed, and a pixel that closes a region emits its result.
//   A pixel outside the image in weighted mode skips the multiplier. No new pixel is
//   taken until the current one is done; the result is registered at emit.
//   A stalled result holds; the last pixel of the following region then waits until
//   the output register is free, and pix_stall_o stays high meanwhile.
//   Reset clears the accumulator, the saturation flag and the configuration
//   (image size 4096, all else zero).
module region_image_moment_accumulator import rima_pkg::*; #(
  parameter int COORD_BITS = 12,
  parameter int MAX_ORDER  = 3
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   pix_valid_i,
  output logic                   pix_stall_o,
  input  logic [COORD_BITS-1:0]  pix_x_i,
  input  logic [COORD_BITS-1:0]  pix_y_i,
  input  logic [7:0]             pix_value_i,
  input  logic                   last_pixel_i,
  output logic                   res_valid_o,
  input  logic                   res_stall_i,
  output logic [63:0]            moment_o,
  output logic                   saturated_o
);

  logic [1:0]   order_x_q, order_y_q;
  logic [15:0]  center_x_q, center_y_q;
  logic         weighted_q;
  logic [12:0]  image_width_q, image_height_q;

  rima_cmd_t    cmd;
  rima_status_t status;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_x_q      <= 2'd0;
      order_y_q      <= 2'd0;
      center_x_q     <= 16'd0;
      center_y_q     <= 16'd0;
      weighted_q     <= 1'b0;
      image_width_q  <= IMAGE_DIM_RESET;
      image_height_q <= IMAGE_DIM_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_ORDER_X:      order_x_q      <= cfg_data_i[1:0];
        CFG_ORDER_Y:      order_y_q      <= cfg_data_i[1:0];
        CFG_CENTER_X:     center_x_q     <= cfg_data_i;
        CFG_CENTER_Y:     center_y_q     <= cfg_data_i;
        CFG_WEIGHTED:     weighted_q     <= cfg_data_i[0];
        CFG_IMAGE_WIDTH:  image_width_q  <= cfg_data_i[12:0];
        CFG_IMAGE_HEIGHT: image_height_q <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  rima_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (pix_valid_i),
    .in_stall_o (pix_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rima_dp #(
    .COORD_BITS (COORD_BITS),
    .MAX_ORDER  (MAX_ORDER)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .order_x_i      (order_x_q),
    .order_y_i      (order_y_q),
    .center_x_i     (center_x_q),
    .center_y_i     (center_y_q),
    .weighted_i     (weighted_q),
    .image_width_i  (image_width_q),
    .image_height_i (image_height_q),
    .pix_x_i        (pix_x_i),
    .pix_y_i        (pix_y_i),
    .pix_value_i    (pix_value_i),
    .last_pixel_i   (last_pixel_i),
    .res_valid_o    (res_valid_o),
    .res_stall_i    (res_stall_i),
    .moment_o       (moment_o),
    .saturated_o    (saturated_o)
  );

endmodule
